### hdl/cca_pkg.sv
// Shared types, constants and helpers for the calendar clock adder.
// Used by cca_ctrl, cca_datapath and calendar_clock_adder_top; depends on nothing.
package cca_pkg;

    localparam int AMOUNT_BITS = 12;
    // The widest sum entering the divider is a stored field plus the amount.
    localparam int DIV_W       = AMOUNT_BITS + 1;
    localparam int YSUM_W      = (DIV_W > 14) ? DIV_W + 1 : 15;

    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_RST   = 14'd1997;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [4:0]  DAY_MAX    = 5'd31;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [5:0]  MINSEC_MAX = 6'd59;

    localparam logic [5:0]  DIV_SIXTY  = 6'd60;
    localparam logic [5:0]  DIV_DAY    = 6'd24;
    localparam logic [5:0]  DIV_YEAR   = 6'd12;

    // Quotients by sixty, twenty-four and twelve as (x * M) >> S with M rounded up.
    // The rounding error of M times the divisor is below 64, so six spare shift bits
    // keep the quotient exact for every DIV_W-bit dividend.
    localparam int RECIP_DIV_SHIFT = DIV_W + 6;
    localparam int RECIP_W         = DIV_W + 3;
    localparam int QPROD_W         = DIV_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_SIXTY =
        RECIP_W'(((1 << RECIP_DIV_SHIFT) + int'(DIV_SIXTY) - 1) / int'(DIV_SIXTY));
    localparam logic [RECIP_W-1:0] RECIP_DAY =
        RECIP_W'(((1 << RECIP_DIV_SHIFT) + int'(DIV_DAY) - 1) / int'(DIV_DAY));
    localparam logic [RECIP_W-1:0] RECIP_YEAR =
        RECIP_W'(((1 << RECIP_DIV_SHIFT) + int'(DIV_YEAR) - 1) / int'(DIV_YEAR));

    // year / 100 as (year * 5243) >> 19, exact for every 14-bit year.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [13:0] CENTURY     = 14'd100;

    typedef enum logic [2:0] {
        FN_LOAD  = 3'd0,
        FN_SEC   = 3'd1,
        FN_MIN   = 3'd2,
        FN_HOUR  = 3'd3,
        FN_DAY   = 3'd4,
        FN_MON   = 3'd5,
        FN_YEAR  = 3'd6,
        FN_CHECK = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        UN_SEC,
        UN_MIN,
        UN_HOUR,
        UN_MON
    } t_unit;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_START,
        DP_DIV_STEP,
        DP_DIV_END,
        DP_WALK_STEP,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        t_func  func;
        t_unit  unit;
    } t_cmd;

    typedef struct packed {
        logic mon_small;   // month plus amount stays within twelve
        logic quot_zero;   // divider quotient is zero
        logic walk_fits;   // day count fits the current month
        logic walk_sat;    // the next month step would carry past the last year
        logic leap_ok;     // leap flag reflects the stored year
    } t_sts;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hdl/cca_ctrl.sv
// Sequencer for the calendar clock adder: handshakes, divider steps and the month walk.
// Depends on cca_pkg; drives cca_datapath through a command struct.
module cca_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cca_pkg::t_func i_func,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  cca_pkg::t_sts  i_sts,
    output cca_pkg::t_cmd  o_cmd
);
    import cca_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DEND,
        ST_WALK,
        ST_FIN
    } t_state;

    t_state                r_state, n_state;
    t_unit                 r_unit, n_unit;
    logic                  r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_unit      = r_unit;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd.op    = DP_NOP;
        o_cmd.func  = i_func;
        o_cmd.unit  = r_unit;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_START;
                    case (i_func)
                        FN_SEC: begin
                            n_unit  = UN_SEC;
                            n_state = ST_DIV;
                        end
                        FN_MIN: begin
                            n_unit  = UN_MIN;
                            n_state = ST_DIV;
                        end
                        FN_HOUR: begin
                            n_unit  = UN_HOUR;
                            n_state = ST_DIV;
                        end
                        FN_DAY: begin
                            n_state = ST_WALK;
                        end
                        FN_MON: begin
                            n_unit  = UN_MON;
                            n_state = i_sts.mon_small ? ST_FIN : ST_DIV;
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_state  = ST_DEND;
            end
            ST_DEND: begin
                o_cmd.op = DP_DIV_END;
                // A carry of zero means the next unit is left untouched.
                case (r_unit)
                    UN_SEC: begin
                        n_unit  = UN_MIN;
                        n_state = i_sts.quot_zero ? ST_FIN : ST_DIV;
                    end
                    UN_MIN: begin
                        n_unit  = UN_HOUR;
                        n_state = i_sts.quot_zero ? ST_FIN : ST_DIV;
                    end
                    UN_HOUR: begin
                        n_state = i_sts.quot_zero ? ST_FIN : ST_WALK;
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_WALK: begin
                if (i_sts.leap_ok) begin
                    o_cmd.op = DP_WALK_STEP;
                    if (i_sts.walk_fits || i_sts.walk_sat) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (i_sts.leap_ok && (!r_out_valid || !i_out_stall)) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_unit      <= UN_SEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_unit      <= n_unit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/cca_datapath.sv
// Datapath of the calendar clock adder: date and time registers, the shared
// constant divider, the month walk, the leap-year unit and the result register.
// Depends on cca_pkg; commanded by cca_ctrl.
module cca_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cca_pkg::t_cmd                    i_cmd,
    output cca_pkg::t_sts                    o_sts,
    input  logic [cca_pkg::AMOUNT_BITS-1:0]  i_amount,
    input  logic [13:0]                      i_load_year,
    input  logic [3:0]                       i_load_month,
    input  logic [4:0]                       i_load_day,
    input  logic [4:0]                       i_load_hour,
    input  logic [5:0]                       i_load_minute,
    input  logic [5:0]                       i_load_second,
    output logic [13:0]                      o_cur_year,
    output logic [3:0]                       o_cur_month,
    output logic [4:0]                       o_cur_day,
    output logic [4:0]                       o_cur_hour,
    output logic [5:0]                       o_cur_minute,
    output logic [5:0]                       o_cur_second,
    output logic                             o_is_valid,
    output logic                             o_overflow
);
    import cca_pkg::*;

    logic [13:0]       r_year, n_year;
    logic [3:0]        r_month, n_month;
    logic [4:0]        r_day, n_day;
    logic [4:0]        r_hour, n_hour;
    logic [5:0]        r_min, n_min;
    logic [5:0]        r_sec, n_sec;
    logic              r_ovf, n_ovf;
    logic [DIV_W-1:0]  r_acc, n_acc;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_d, n_d;
    logic [7:0]        r_q100;
    logic              r_fresh;

    logic [13:0]       r_out_year;
    logic [3:0]        r_out_month;
    logic [4:0]        r_out_day;
    logic [4:0]        r_out_hour;
    logic [5:0]        r_out_min;
    logic [5:0]        r_out_sec;
    logic              r_out_valid_flag;
    logic              r_out_ovf;

    logic [26:0]        w_prod;
    logic [13:0]        w_century;
    logic               w_leap;
    logic [4:0]         w_len;
    logic               w_legal;
    logic [5:0]         w_divisor;
    logic [RECIP_W-1:0] w_recip;
    logic [QPROD_W-1:0] w_qprod;
    logic [DIV_W-1:0]   w_rem;
    logic [DIV_W-1:0]   w_mon_sum;
    logic [YSUM_W-1:0]  w_ysum;
    logic [4:0]         w_mnext;
    logic               w_mwrap;
    logic               w_fits;
    logic               w_year_we;

    // Leap year: the quotient by one hundred is registered, so the flag follows
    // a year update in the next cycle and the sequencer waits on leap_ok.
    assign w_prod    = {13'd0, r_year} * {14'd0, RECIP_100};
    assign w_century = 14'(r_q100) * CENTURY;
    assign w_leap    = (r_year == w_century) ? (r_q100[1:0] == 2'd0) : (r_year[1:0] == 2'd0);
    assign w_len     = month_len(r_month, w_leap);

    assign w_legal = (r_year != 14'd0) && (r_month != 4'd0) && (r_month <= MONTH_MAX)
                  && (r_day != 5'd0) && (r_day <= w_len) && (r_hour <= HOUR_MAX)
                  && (r_min <= MINSEC_MAX) && (r_sec <= MINSEC_MAX);

    always_comb begin
        case (i_cmd.unit)
            UN_HOUR: begin
                w_divisor = DIV_DAY;
                w_recip   = RECIP_DAY;
            end
            UN_MON: begin
                w_divisor = DIV_YEAR;
                w_recip   = RECIP_YEAR;
            end
            default: begin
                w_divisor = DIV_SIXTY;
                w_recip   = RECIP_SIXTY;
            end
        endcase
    end

    // The quotient is registered into r_quo by DP_DIV_STEP; DP_DIV_END forms the remainder from it.
    assign w_qprod   = QPROD_W'(r_acc) * QPROD_W'(w_recip);
    assign w_rem     = r_acc - r_quo * DIV_W'(w_divisor);
    assign w_mon_sum = DIV_W'(r_month) + DIV_W'(i_amount);
    assign w_mnext   = 5'(r_month) + 5'd1;
    assign w_mwrap   = (w_mnext > 5'(MONTH_MAX));
    assign w_fits    = (r_d <= DIV_W'(w_len));

    always_comb begin
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_hour    = r_hour;
        n_min     = r_min;
        n_sec     = r_sec;
        n_ovf     = r_ovf;
        n_acc     = r_acc;
        n_quo     = r_quo;
        n_d       = r_d;
        w_ysum    = '0;
        w_year_we = 1'b0;

        case (i_cmd.op)
            DP_START: begin
                n_ovf = 1'b0;
                case (i_cmd.func)
                    FN_LOAD: begin
                        w_year_we = 1'b1;
                        if (i_load_year > YEAR_MAX) begin
                            n_year = YEAR_MAX;
                            n_ovf  = 1'b1;
                        end else begin
                            n_year = i_load_year;
                        end
                        n_month = i_load_month;
                        n_day   = i_load_day;
                        n_hour  = i_load_hour;
                        n_min   = i_load_minute;
                        n_sec   = i_load_second;
                    end
                    FN_SEC:  n_acc = DIV_W'(r_sec) + DIV_W'(i_amount);
                    FN_MIN:  n_acc = DIV_W'(r_min) + DIV_W'(i_amount);
                    FN_HOUR: n_acc = DIV_W'(r_hour) + DIV_W'(i_amount);
                    FN_DAY:  n_d   = DIV_W'(r_day) + DIV_W'(i_amount);
                    FN_MON: begin
                        if (w_mon_sum > DIV_W'(MONTH_MAX)) begin
                            n_acc = w_mon_sum - 1'b1;
                        end else begin
                            n_month = w_mon_sum[3:0];
                        end
                    end
                    FN_YEAR: begin
                        w_year_we = 1'b1;
                        w_ysum    = YSUM_W'(r_year) + YSUM_W'(i_amount);
                        if (w_ysum > YSUM_W'(YEAR_MAX)) begin
                            n_year = YEAR_MAX;
                            n_ovf  = 1'b1;
                        end else begin
                            n_year = w_ysum[13:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            DP_DIV_STEP: begin
                n_quo = DIV_W'(w_qprod[QPROD_W-1:RECIP_DIV_SHIFT]);
            end
            DP_DIV_END: begin
                // r_quo holds the quotient, w_rem the remainder.
                case (i_cmd.unit)
                    UN_SEC: begin
                        n_sec = w_rem[5:0];
                        n_acc = DIV_W'(r_min) + r_quo;
                    end
                    UN_MIN: begin
                        n_min = w_rem[5:0];
                        n_acc = DIV_W'(r_hour) + r_quo;
                    end
                    UN_HOUR: begin
                        n_hour = w_rem[4:0];
                        n_d    = DIV_W'(r_day) + r_quo;
                    end
                    default: begin
                        w_year_we = 1'b1;
                        n_month   = w_rem[3:0] + 4'd1;
                        w_ysum    = YSUM_W'(r_year) + YSUM_W'(r_quo);
                        if (w_ysum > YSUM_W'(YEAR_MAX)) begin
                            n_year  = YEAR_MAX;
                            n_month = MONTH_MAX;
                            n_day   = DAY_MAX;
                            n_hour  = HOUR_MAX;
                            n_min   = MINSEC_MAX;
                            n_sec   = MINSEC_MAX;
                            n_ovf   = 1'b1;
                        end else begin
                            n_year = w_ysum[13:0];
                        end
                    end
                endcase
            end
            DP_WALK_STEP: begin
                if (w_fits) begin
                    n_day = r_d[4:0];
                end else begin
                    n_d     = r_d - DIV_W'(w_len);
                    n_month = w_mwrap ? 4'(w_mnext - 5'(MONTH_MAX)) : w_mnext[3:0];
                    if (w_mwrap) begin
                        w_year_we = 1'b1;
                        if (r_year == YEAR_MAX) begin
                            n_year  = YEAR_MAX;
                            n_month = MONTH_MAX;
                            n_day   = DAY_MAX;
                            n_hour  = HOUR_MAX;
                            n_min   = MINSEC_MAX;
                            n_sec   = MINSEC_MAX;
                            n_ovf   = 1'b1;
                        end else begin
                            n_year = r_year + 14'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= YEAR_RST;
            r_month <= 4'd1;
            r_day   <= 5'd1;
            r_hour  <= 5'd1;
            r_min   <= 6'd1;
            r_sec   <= 6'd1;
            r_ovf   <= 1'b0;
            r_fresh <= 1'b0;
        end else begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_ovf   <= n_ovf;
            r_fresh <= !w_year_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_quo  <= n_quo;
        r_d    <= n_d;
        r_q100 <= w_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        if (i_cmd.op == DP_OUT) begin
            r_out_year       <= r_year;
            r_out_month      <= r_month;
            r_out_day        <= r_day;
            r_out_hour       <= r_hour;
            r_out_min        <= r_min;
            r_out_sec        <= r_sec;
            r_out_valid_flag <= w_legal;
            r_out_ovf        <= r_ovf;
        end
    end

    assign o_sts.mon_small = (w_mon_sum <= DIV_W'(MONTH_MAX));
    assign o_sts.quot_zero = (r_quo == '0);
    assign o_sts.walk_fits = w_fits;
    assign o_sts.walk_sat  = !w_fits && w_mwrap && (r_year == YEAR_MAX);
    assign o_sts.leap_ok   = r_fresh;

    assign o_cur_year   = r_out_year;
    assign o_cur_month  = r_out_month;
    assign o_cur_day    = r_out_day;
    assign o_cur_hour   = r_out_hour;
    assign o_cur_minute = r_out_min;
    assign o_cur_second = r_out_sec;
    assign o_is_valid   = r_out_valid_flag;
    assign o_overflow   = r_out_ovf;

endmodule

### hdl/calendar_clock_adder_top.sv
// Top level of the calendar clock adder: joins the sequencer and the datapath.
// Depends on cca_pkg, cca_ctrl and cca_datapath.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------------
//   in       | input     | i_in_valid / o_in_stall | i_func, i_amount, i_load_*
//   out      | output    | o_out_valid / i_out_stall | o_cur_*, o_is_valid, o_overflow
//
// A check goes straight to the result, and loads and year adds wait there while the leap flag
// settles after the year write. Second, minute, hour and month adds divide by a constant
// with a divide step and an end step per unit carried; day carries then walk one month per
// cycle, pausing after each year carry until the leap flag settles.
// Reset is synchronous and loads 1997-01-01 01:01:01. One result beat may wait
// under i_out_stall while the next input beat is taken and worked on.
module calendar_clock_adder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [2:0]                       i_func,
    input  logic [cca_pkg::AMOUNT_BITS-1:0]  i_amount,
    input  logic [13:0]                      i_load_year,
    input  logic [3:0]                       i_load_month,
    input  logic [4:0]                       i_load_day,
    input  logic [4:0]                       i_load_hour,
    input  logic [5:0]                       i_load_minute,
    input  logic [5:0]                       i_load_second,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [13:0]                      o_cur_year,
    output logic [3:0]                       o_cur_month,
    output logic [4:0]                       o_cur_day,
    output logic [4:0]                       o_cur_hour,
    output logic [5:0]                       o_cur_minute,
    output logic [5:0]                       o_cur_second,
    output logic                             o_is_valid,
    output logic                             o_overflow
);
    import cca_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (t_func'(i_func)),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cca_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_amount      (i_amount),
        .i_load_year   (i_load_year),
        .i_load_month  (i_load_month),
        .i_load_day    (i_load_day),
        .i_load_hour   (i_load_hour),
        .i_load_minute (i_load_minute),
        .i_load_second (i_load_second),
        .o_cur_year    (o_cur_year),
        .o_cur_month   (o_cur_month),
        .o_cur_day     (o_cur_day),
        .o_cur_hour    (o_cur_hour),
        .o_cur_minute  (o_cur_minute),
        .o_cur_second  (o_cur_second),
        .o_is_valid    (o_is_valid),
        .o_overflow    (o_overflow)
    );

endmodule
